[hdl/ffba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and codes for the first-fit block allocator
// Map entry states, request kinds, datapath operations and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int BLOCK_BYTES_DEF = 256;
	localparam int NUM_BLOCKS_DEF  = 256;

	localparam logic [1:0] ST_FREE = 2'd0;
	localparam logic [1:0] ST_HEAD = 2'd1;
	localparam logic [1:0] ST_CONT = 2'd2;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_START,
		OP_CLEAR,
		OP_SCAN_A,
		OP_MARK,
		OP_LOCATE,
		OP_SCAN_F
	} op_t;

	typedef enum logic [1:0] {
		RSP_FAIL,
		RSP_OK,
		RSP_ALLOC,
		RSP_FREE
	} rsp_t;

	typedef struct packed {
		logic load;
		op_t  op;
		logic rsp_en;
		rsp_t rsp;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       bytes_zero;
		logic       last;
		logic       a_found;
		logic       a_fail;
		logic       mark_last;
		logic       loc_hit;
		logic       loc_miss;
		logic       f_bad;
		logic       f_done;
	} sts_t;

endpackage

[hdl/first_fit_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit contiguous block allocator
// Keeps a two-bit state per block in an on-chip map and serves allocate,
// free and clear requests one at a time.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  request   start, busy         req_type, alloc_bytes, free_offset
//  result    done (1-cycle)      status, block_offset, freed_bytes
//
//  Each request is first dispatched. Allocate then scans the map and marks
//  the run it found; free locates the head block, releases its run and then
//  posts the result; clear sweeps the map; a zero-size allocate or an unknown
//  type is answered at dispatch. The map is walked one entry per cycle.
//  After reset busy stays high while the map is swept.
//  done rises as busy falls and lasts one cycle; results cannot be held off.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
	parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF,
	parameter int NUM_BLOCKS  = ffba_pkg::NUM_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [16:0] alloc_bytes,
	input  logic [15:0] free_offset,
	output logic        done,
	output logic        status,
	output logic [15:0] block_offset,
	output logic [15:0] freed_bytes
);
	import ffba_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic accept;

	assign accept = start && !busy;

	ffba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ffba_dpath #(
		.BLOCK_BYTES (BLOCK_BYTES),
		.NUM_BLOCKS  (NUM_BLOCKS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_type     (req_type),
		.alloc_bytes  (alloc_bytes),
		.free_offset  (free_offset),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.status       (status),
		.block_offset (block_offset),
		.freed_bytes  (freed_bytes)
	);

endmodule

[hdl/ffba_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_dpath: allocator datapath
// Block map memory, scan pointer, byte accumulator, request and result
// registers. Executes one operation per cycle as commanded.
// ----------------------------------------------------------------------------
module ffba_dpath #(
	parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF,
	parameter int NUM_BLOCKS  = ffba_pkg::NUM_BLOCKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      req_type,
	input  logic [16:0]     alloc_bytes,
	input  logic [15:0]     free_offset,
	input  ffba_pkg::cmd_t  cmd,
	output ffba_pkg::sts_t  sts,
	output logic            done,
	output logic            status,
	output logic [15:0]     block_offset,
	output logic [15:0]     freed_bytes
);
	import ffba_pkg::*;

	localparam int IDX_W  = $clog2(NUM_BLOCKS);
	localparam int PTR_W  = $clog2(NUM_BLOCKS + 1);
	localparam int SPAN_W = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
	localparam int AW     = (SPAN_W > 18) ? SPAN_W : 18;
	localparam logic [AW-1:0]    BB       = AW'(BLOCK_BYTES);
	localparam logic [AW-1:0]    SAT      = AW'(16'hFFFF);
	localparam logic [PTR_W-1:0] PTR_END  = PTR_W'(NUM_BLOCKS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BLOCKS - 1);

	logic [1:0]       mem [NUM_BLOCKS];
	logic [1:0]       req_type_q;
	logic [16:0]      bytes_q;
	logic [15:0]      off_q;
	logic [PTR_W-1:0] ptr_q;
	logic [AW-1:0]    acc_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] end_q;
	logic [1:0]       rd_s1;
	logic             v_s1;
	logic [IDX_W-1:0] eidx_s1;
	logic             done_q;
	logic             status_q;
	logic [15:0]      offset_q;
	logic [15:0]      freed_q;

	logic [IDX_W-1:0] ptr_idx;
	logic             ptr_in;
	logic [AW-1:0]    acc_inc;
	logic [AW-1:0]    bytes_ext;
	logic [AW-1:0]    off_ext;
	logic [AW-1:0]    prod;
	logic             rd_en;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [1:0]       wdata;
	logic             a_free;
	logic [IDX_W-1:0] first_idx;
	logic             head_pos;
	logic             f_ok;

	assign ptr_idx   = ptr_q[IDX_W-1:0];
	assign ptr_in    = ptr_q < PTR_END;
	assign acc_inc   = acc_q + BB;
	assign bytes_ext = AW'(bytes_q);
	assign off_ext   = AW'(off_q);
	assign prod      = AW'(start_q) * BB;
	assign a_free    = rd_s1 == ST_FREE;
	assign first_idx = (acc_q == '0) ? eidx_s1 : start_q;
	assign head_pos  = eidx_s1 == start_q;
	assign f_ok      = head_pos ? (rd_s1 == ST_HEAD) : (rd_s1 == ST_CONT);
	assign rd_en     = ((cmd.op == OP_SCAN_A) || (cmd.op == OP_SCAN_F)) && ptr_in;

	always_comb begin
		we    = 1'b0;
		waddr = ptr_idx;
		wdata = ST_FREE;
		unique case (cmd.op)
			OP_CLEAR: begin
				we    = 1'b1;
				wdata = (ptr_q == '0) ? ST_HEAD : ST_FREE;
			end
			OP_MARK: begin
				we    = 1'b1;
				wdata = (ptr_idx == start_q) ? ST_HEAD : ST_CONT;
			end
			OP_SCAN_F: begin
				we    = v_s1 && f_ok;
				waddr = eidx_s1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_comb begin
		sts            = '0;
		sts.req_type   = req_type_q;
		sts.bytes_zero = bytes_q == '0;
		sts.last       = ptr_q == PTR_W'(NUM_BLOCKS - 1);
		sts.a_found    = v_s1 && a_free && (acc_inc >= bytes_ext);
		sts.a_fail     = v_s1 && (eidx_s1 == IDX_LAST);
		sts.mark_last  = ptr_idx == end_q;
		sts.loc_hit    = ptr_in && (acc_q == off_ext) && (ptr_q != '0);
		sts.loc_miss   = !ptr_in || (acc_q > off_ext) || ((acc_q == off_ext) && (ptr_q == '0));
		sts.f_bad      = v_s1 && head_pos && !f_ok;
		sts.f_done     = v_s1 && ((!head_pos && !f_ok) || (f_ok && (eidx_s1 == IDX_LAST)));
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_s1 <= mem[ptr_idx];
		end
	end

	always_ff @(posedge clk) begin
		eidx_s1 <= ptr_idx;
		if (cmd.load) begin
			req_type_q <= req_type;
			bytes_q    <= alloc_bytes;
			off_q      <= free_offset;
		end
		if (cmd.op == OP_SCAN_A && v_s1) begin
			if (a_free && acc_q == '0) begin
				start_q <= eidx_s1;
			end
			if (sts.a_found) begin
				end_q <= eidx_s1;
			end
		end
		if (cmd.op == OP_LOCATE && sts.loc_hit) begin
			start_q <= ptr_idx;
		end
		if (cmd.rsp_en) begin
			status_q <= 1'b0;
			offset_q <= '0;
			freed_q  <= '0;
			case (cmd.rsp)
				RSP_FAIL:  status_q <= 1'b1;
				RSP_ALLOC: offset_q <= prod[15:0];
				RSP_FREE:  freed_q  <= (acc_q > SAT) ? 16'hFFFF : acc_q[15:0];
				default:   status_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			acc_q  <= '0;
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= rd_en;
			done_q <= cmd.rsp_en;
			unique case (cmd.op)
				OP_START: begin
					ptr_q <= '0;
					acc_q <= '0;
				end
				OP_CLEAR, OP_MARK: begin
					ptr_q <= ptr_q + 1'b1;
				end
				OP_SCAN_A: begin
					if (ptr_in) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (v_s1) begin
						acc_q <= a_free ? acc_inc : '0;
						if (sts.a_found) begin
							ptr_q <= PTR_W'(first_idx);
						end
					end
				end
				OP_LOCATE: begin
					if (sts.loc_hit) begin
						acc_q <= '0;
					end else begin
						acc_q <= acc_inc;
						ptr_q <= ptr_q + 1'b1;
					end
				end
				OP_SCAN_F: begin
					if (ptr_in) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (v_s1 && f_ok) begin
						acc_q <= acc_inc;
					end
				end
				default: begin
					ptr_q <= ptr_q;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign block_offset = offset_q;
	assign freed_bytes  = freed_q;

`ifndef SYNTHESIS
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(we && rd_en) |-> (waddr != ptr_idx))
		else $error("map read and write hit the same entry");
	a_mark_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MARK) |-> (ptr_q <= PTR_W'(end_q)))
		else $error("marking ran past the end of the run");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q) |-> (offset_q == '0 && freed_q == '0))
		else $error("failed request returned nonzero fields");
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(offset_q != '0 && freed_q != '0))
		else $error("offset and freed bytes both set");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_en |=> (done_q && $past(cmd.op) != OP_SCAN_A || $past(cmd.rsp) != RSP_ALLOC))
		else $error("alloc result issued mid-scan");
`endif

endmodule

[hdl/ffba_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl: allocator controller
// Sequences the reset sweep, dispatch, scan, mark and release phases and
// tells the datapath when to post a result.
// ----------------------------------------------------------------------------
module ffba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  ffba_pkg::sts_t  sts,
	output ffba_pkg::cmd_t  cmd,
	output logic            busy
);
	import ffba_pkg::*;

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_CLR   = 4'd3;
	localparam logic [3:0] S_ASCAN = 4'd4;
	localparam logic [3:0] S_AMARK = 4'd5;
	localparam logic [3:0] S_FLOC  = 4'd6;
	localparam logic [3:0] S_FSCAN = 4'd7;
	localparam logic [3:0] S_FRESP = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.op     = OP_NONE;
		cmd.rsp    = RSP_FAIL;
		unique case (state_q)
			S_INIT: begin
				cmd.op = OP_CLEAR;
				if (sts.last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.req_type)
					REQ_ALLOC: begin
						if (sts.bytes_zero) begin
							cmd.rsp_en = 1'b1;
							state_d    = S_IDLE;
						end else begin
							cmd.op  = OP_START;
							state_d = S_ASCAN;
						end
					end
					REQ_FREE: begin
						cmd.op  = OP_START;
						state_d = S_FLOC;
					end
					REQ_CLEAR: begin
						cmd.op  = OP_START;
						state_d = S_CLR;
					end
					default: begin
						cmd.rsp_en = 1'b1;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_CLR: begin
				cmd.op = OP_CLEAR;
				if (sts.last) begin
					cmd.rsp_en = 1'b1;
					cmd.rsp    = RSP_OK;
					state_d    = S_IDLE;
				end
			end
			S_ASCAN: begin
				cmd.op = OP_SCAN_A;
				if (sts.a_found) begin
					state_d = S_AMARK;
				end else if (sts.a_fail) begin
					cmd.rsp_en = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_AMARK: begin
				cmd.op = OP_MARK;
				if (sts.mark_last) begin
					cmd.rsp_en = 1'b1;
					cmd.rsp    = RSP_ALLOC;
					state_d    = S_IDLE;
				end
			end
			S_FLOC: begin
				cmd.op = OP_LOCATE;
				if (sts.loc_hit) begin
					state_d = S_FSCAN;
				end else if (sts.loc_miss) begin
					cmd.rsp_en = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_FSCAN: begin
				cmd.op = OP_SCAN_F;
				if (sts.f_bad) begin
					cmd.rsp_en = 1'b1;
					state_d    = S_IDLE;
				end else if (sts.f_done) begin
					state_d = S_FRESP;
				end
			end
			S_FRESP: begin
				cmd.rsp_en = 1'b1;
				cmd.rsp    = RSP_FREE;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

`ifndef SYNTHESIS
	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_en |=> (state_q == S_IDLE))
		else $error("result posted without returning to idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (busy && state_q == S_DISP))
		else $error("request loaded outside idle");
	a_found_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ASCAN && sts.a_found) |=> (cmd.op == OP_MARK))
		else $error("found run not marked");
`endif

endmodule

[test/first_fit_block_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb: self-checking bench for the block allocator
// A queue of requests is planned up front: a directed opening set, then
// random allocate, free, clear and unknown requests. Frees mostly target
// live allocations. A clocked driver issues them over start/busy with random
// idle bursts. A shadow block map predicts each result when it is accepted,
// and a clocked monitor checks every done strobe against the oldest
// prediction.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
	import ffba_pkg::*;

	localparam int BB = BLOCK_BYTES_DEF;
	localparam int NB = NUM_BLOCKS_DEF;
	localparam int N_RANDOM = 1400;
	localparam int DRAIN_CYCLES = 2 * NB + 64;
	localparam int CYCLE_LIMIT = 5_000_000;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam logic RES_OK   = 1'b0;
	localparam logic RES_FAIL = 1'b1;

	typedef logic [NB-1:0][1:0] block_map_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [16:0] bytes;
		logic [15:0] offset;
		logic [1:0]  idle_after;
	} request_t;

	typedef struct packed {
		logic        status;
		logic [15:0] block_offset;
		logic [15:0] freed_bytes;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  req_type = REQ_ALLOC;
	logic [16:0] alloc_bytes = '0;
	logic [15:0] free_offset = '0;
	logic        busy;
	logic        done;
	logic        status;
	logic [15:0] block_offset;
	logic [15:0] freed_bytes;

	request_t    pending_reqs[$];
	result_t     expected_results[$];
	block_map_t  plan_map;
	block_map_t  live_map;
	int          planned_count = 0;
	int          accepted_count = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	logic [1:0]  idle_left = '0;

	first_fit_block_allocator #(
		.BLOCK_BYTES(BB),
		.NUM_BLOCKS(NB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.alloc_bytes(alloc_bytes),
		.free_offset(free_offset),
		.done(done),
		.status(status),
		.block_offset(block_offset),
		.freed_bytes(freed_bytes)
	);

	function automatic block_map_t empty_map();
		block_map_t m;
		m = '0;
		m[0] = ST_HEAD;
		return m;
	endfunction

	// first-fit allocate / free / clear against a block map
	function automatic result_t serve_request(inout block_map_t m, input request_t rq);
		result_t rs;
		int need, run, first, k, blk, released;
		bit scanning;
		rs = '0;
		rs.status = RES_FAIL;
		case (rq.kind)
			REQ_ALLOC: begin
				if (rq.bytes != 0) begin
					need = (int'(rq.bytes) + BB - 1) / BB;
					run = 0;
					first = -1;
					for (k = 0; k < NB; k++) begin
						if (first < 0) begin
							run = (m[k] == ST_FREE) ? run + 1 : 0;
							if (run == need)
								first = k + 1 - need;
						end
					end
					if (first >= 0) begin
						for (k = first; k < first + need; k++)
							m[k] = (k == first) ? ST_HEAD : ST_CONT;
						rs.status = RES_OK;
						rs.block_offset = 16'(first * BB);
					end
				end
			end
			REQ_FREE: begin
				blk = int'(rq.offset) / BB;
				if (int'(rq.offset) % BB == 0 && blk != 0 && blk < NB && m[blk] == ST_HEAD) begin
					m[blk] = ST_FREE;
					released = BB;
					scanning = 1'b1;
					for (k = blk + 1; k < NB; k++) begin
						if (scanning && m[k] == ST_CONT) begin
							m[k] = ST_FREE;
							released += BB;
						end else begin
							scanning = 1'b0;
						end
					end
					rs.status = RES_OK;
					rs.freed_bytes = (released > 65535) ? 16'hFFFF : 16'(released);
				end
			end
			REQ_CLEAR: begin
				m = empty_map();
				rs.status = RES_OK;
			end
			default: ;
		endcase
		return rs;
	endfunction

	// random block in 1..NB-1 holding the given state, 0 if there is none
	function automatic int pick_block(input block_map_t m, input logic [1:0] want);
		int hits, k, choice;
		hits = 0;
		for (k = 1; k < NB; k++)
			if (m[k] == want)
				hits++;
		if (hits == 0)
			return 0;
		choice = $urandom_range(0, hits - 1);
		for (k = 1; k < NB; k++) begin
			if (m[k] == want) begin
				if (choice == 0)
					return k;
				choice--;
			end
		end
		return 0;
	endfunction

	// fields a request kind ignores get random values
	task automatic add_request(input logic [1:0] kind, input int unsigned val, input bit idle_ok);
		request_t rq;
		rq.kind = kind;
		rq.bytes = (kind == REQ_ALLOC) ? 17'(val) : 17'($urandom_range(0, 65536));
		rq.offset = (kind == REQ_FREE) ? 16'(val) : 16'($urandom_range(0, 65535));
		rq.idle_after = (idle_ok && $urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
		void'(serve_request(plan_map, rq));
		pending_reqs.push_back(rq);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin : drive_requests
		request_t taken, nxt;
		if (!arst_n) begin
			start <= 1'b0;
			req_type <= REQ_ALLOC;
			alloc_bytes <= '0;
			free_offset <= '0;
			idle_left <= '0;
		end else begin
			if (start && !busy) begin
				taken = '0;
				taken.kind = req_type;
				taken.bytes = alloc_bytes;
				taken.offset = free_offset;
				expected_results.push_back(serve_request(live_map, taken));
				accepted_count++;
			end
			if (!start || !busy) begin
				if (idle_left != 0) begin
					start <= 1'b0;
					idle_left <= idle_left - 2'd1;
				end else if (pending_reqs.size() != 0) begin
					nxt = pending_reqs.pop_front();
					start <= 1'b1;
					req_type <= nxt.kind;
					alloc_bytes <= nxt.bytes;
					free_offset <= nxt.offset;
					idle_left <= nxt.idle_after;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: status %0d offset %0d freed %0d",
						status, block_offset, freed_bytes);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status || block_offset !== want.block_offset
						|| freed_bytes !== want.freed_bytes) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected status %0d offset %0d freed %0d, got status %0d offset %0d freed %0d",
							want.status, want.block_offset, want.freed_bytes,
							status, block_offset, freed_bytes);
				end
			end
		end
	end

	initial begin : run_test
		int r, blk, blocks, pick;
		bit idle_window;
		plan_map = empty_map();
		live_map = empty_map();

		add_request(REQ_ALLOC, 0, 1'b1);
		add_request(REQ_ALLOC, 1, 1'b1);
		add_request(REQ_ALLOC, BB, 1'b1);
		add_request(REQ_ALLOC, BB + 1, 1'b1);
		add_request(REQ_FREE, 0, 1'b1);
		add_request(REQ_FREE, BB + 1, 1'b1);
		add_request(REQ_FREE, 4 * BB, 1'b1);
		add_request(REQ_FREE, 3 * BB, 1'b1);
		add_request(REQ_FREE, 3 * BB, 1'b1);
		add_request(REQ_ALLOC, 65536, 1'b1);
		add_request(REQ_UNKNOWN, 0, 1'b1);
		add_request(REQ_CLEAR, 0, 1'b1);
		add_request(REQ_ALLOC, (NB - 1) * BB, 1'b1);
		add_request(REQ_FREE, 65535, 1'b1);
		add_request(REQ_FREE, (NB - 1) * BB, 1'b1);
		add_request(REQ_FREE, BB, 1'b1);
		add_request(REQ_CLEAR, 0, 1'b1);
		// fragmented pool: two single free blocks apart
		add_request(REQ_ALLOC, BB, 1'b1);
		add_request(REQ_ALLOC, BB, 1'b1);
		add_request(REQ_ALLOC, BB, 1'b1);
		add_request(REQ_ALLOC, (NB - 4) * BB, 1'b1);
		add_request(REQ_FREE, BB, 1'b1);
		add_request(REQ_FREE, 3 * BB, 1'b1);
		add_request(REQ_ALLOC, 2 * BB, 1'b1);
		add_request(REQ_ALLOC, BB - 1, 1'b1);
		add_request(REQ_CLEAR, 0, 1'b1);

		idle_window = 1'b1;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 64 == 0)
				idle_window = $urandom_range(0, 1);
			idle_window = idle_window && (i < N_RANDOM * 7 / 8);
			r = $urandom_range(0, 99);
			if (r < 48) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					blocks = $urandom_range(1, 8);
					add_request(REQ_ALLOC, (blocks - 1) * BB + $urandom_range(1, BB), idle_window);
				end else if (pick < 90) begin
					blocks = $urandom_range(9, 64);
					add_request(REQ_ALLOC, (blocks - 1) * BB + $urandom_range(1, BB), idle_window);
				end else if (pick < 98) begin
					add_request(REQ_ALLOC, $urandom_range(0, 65536), idle_window);
				end else begin
					add_request(REQ_ALLOC, 0, idle_window);
				end
			end else if (r < 96) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					blk = pick_block(plan_map, ST_HEAD);
					add_request(REQ_FREE, blk * BB, idle_window);
				end else if (pick == 7) begin
					blk = pick_block(plan_map, ST_CONT);
					add_request(REQ_FREE, blk * BB, idle_window);
				end else if (pick == 8) begin
					blk = $urandom_range(0, NB - 1);
					add_request(REQ_FREE, blk * BB + $urandom_range(1, BB - 1), idle_window);
				end else begin
					add_request(REQ_FREE, $urandom_range(0, 65535), idle_window);
				end
			end else if (r < 98) begin
				add_request(REQ_CLEAR, 0, idle_window);
			end else begin
				add_request(REQ_UNKNOWN, 0, idle_window);
			end
		end
		planned_count = pending_reqs.size();

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted_count < planned_count || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
